FILE: hw/rtl/mtwd_pkg.sv
// ----------------------------------------------------------------------------
// mtwd_pkg
// shared types, widths and codes for the multi-tap wake detector
// ----------------------------------------------------------------------------
package mtwd_pkg;

   // payload widths
   localparam int COORD_BITS  = 12;
   localparam int TIME_BITS   = 32;
   localparam int OP_BITS     = 3;
   localparam int TAPS_BITS   = 4;

   // configuration register widths
   localparam int TAP_CNT_BITS  = 4;
   localparam int FEATHER_BITS  = 12;
   localparam int STEP_BITS     = 10;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 12;

   // window = step * (tap_count + 1)
   localparam int MULT_BITS   = TAP_CNT_BITS + 1;
   localparam int WINDOW_BITS = STEP_BITS + MULT_BITS;
   localparam int DIST_BITS   = (COORD_BITS > FEATHER_BITS) ? COORD_BITS : FEATHER_BITS;

   // reset values of the configuration registers
   localparam logic [TAP_CNT_BITS-1:0] TAP_COUNT_RST = TAP_CNT_BITS'(1);
   localparam logic [FEATHER_BITS-1:0] FEATHER_RST   = FEATHER_BITS'(200);
   localparam logic [STEP_BITS-1:0]    STEP_RST      = STEP_BITS'(100);

   // request beat layout: coord, now, screen_off from bit 0 up
   localparam int REQ_COORD_LSB  = 0;
   localparam int REQ_NOW_LSB    = REQ_COORD_LSB + COORD_BITS;
   localparam int REQ_SOFF_BIT   = REQ_NOW_LSB + TIME_BITS;
   localparam int REQ_FIELD_BITS = REQ_SOFF_BIT + 1;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;

   // response beat layout: wake, taps_seen from bit 0 up
   localparam int RSP_WAKE_BIT   = 0;
   localparam int RSP_TAPS_LSB   = 1;
   localparam int RSP_FIELD_BITS = RSP_TAPS_LSB + TAPS_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   typedef enum logic [OP_BITS-1:0] {
      OP_SLOT         = 3'd0,
      OP_RELEASE      = 3'd1,
      OP_POS_X        = 3'd2,
      OP_POS_Y        = 3'd3,
      OP_SUSPEND_EXIT = 3'd4
   } op_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_TAP_COUNT   = 2'd0,
      CSR_FEATHER     = 2'd1,
      CSR_WINDOW_STEP = 2'd2
   } csr_index_type;

endpackage

FILE: hw/rtl/multi_tap_wake_detector.sv
// ----------------------------------------------------------------------------
// multi_tap_wake_detector
// counts nearby, timely taps while the screen is off and flags a wake event
// ----------------------------------------------------------------------------
// pipeline: an accepted req beat passes the input register, then the result register,
//   which holds its rsp beat; every req beat gives exactly one rsp beat
// throughput: 1 beat per cycle while rsp_tready does not stall the result register;
//   the tap update between the input register and the result register is combinational
// reset: synchronous, active high; clears the pipeline valids and the tap
//   state (armed is set), loads the configuration defaults (tap_count 1, feather 200, step 100)
module multi_tap_wake_detector (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: coord_value, now_ms, screen_off (lowest bit up), zero padded
   input  logic [mtwd_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // tuser: operation
   input  logic [mtwd_pkg::OP_BITS-1:0]        req_tuser,
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: wake, taps_seen (lowest bit up), zero padded
   output logic [mtwd_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // configuration writes
   input  logic                                csr_we,
   input  logic [mtwd_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [mtwd_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import mtwd_pkg::*;

   // configuration registers
   logic [TAP_CNT_BITS-1:0] tap_count_ff;
   logic [FEATHER_BITS-1:0] feather_ff;
   logic [STEP_BITS-1:0]    step_ff;

   // input register stage
   logic                    s1_valid_ff;
   op_type                  s1_op_ff;
   logic [COORD_BITS-1:0]   s1_coord_ff;
   logic [TIME_BITS-1:0]    s1_now_ff;
   logic                    s1_soff_ff;

   // result register stage
   logic                    rsp_valid_ff;
   logic                    rsp_wake_ff;
   logic [TAPS_BITS-1:0]    rsp_taps_ff;

   // tap tracking state
   logic [TAPS_BITS-1:0]    counter_ff,   counter_in;
   logic [TIME_BITS-1:0]    last_time_ff, last_time_in;
   logic [COORD_BITS-1:0]   last_x_ff,    last_x_in;
   logic [COORD_BITS-1:0]   last_y_ff,    last_y_in;
   logic [COORD_BITS-1:0]   cur_x_ff,     cur_x_in;
   logic [COORD_BITS-1:0]   cur_y_ff,     cur_y_in;
   logic                    armed_ff,     armed_in;
   logic                    susp_ff,      susp_in;
   logic [TIME_BITS-1:0]    susp_time_ff, susp_time_in;
   logic                    wake_in;

   // handshake: the whole pipe moves when the result register is free
   logic advance;
   logic s1_fire;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && advance;
   assign req_tready = !s1_valid_ff || advance;

   // per-item datapath terms
   logic [MULT_BITS-1:0]    mult;
   logic [WINDOW_BITS-1:0]  window;
   logic [TIME_BITS-1:0]    tap_gap;
   logic [TIME_BITS-1:0]    susp_gap;
   logic [COORD_BITS-1:0]   pos_x;
   logic [COORD_BITS-1:0]   pos_y;
   logic [COORD_BITS-1:0]   dx;
   logic [COORD_BITS-1:0]   dy;
   logic                    near;
   logic                    tap_in_window;
   logic                    susp_in_window;
   logic [TAP_CNT_BITS-1:0] tc_less_one;
   logic [MULT_BITS-1:0]    cnt_next;
   logic                    rec;

   assign mult     = MULT_BITS'(tap_count_ff) + MULT_BITS'(1);
   assign window   = WINDOW_BITS'(step_ff) * WINDOW_BITS'(mult);
   assign tap_gap  = s1_now_ff - last_time_ff;
   assign susp_gap = s1_now_ff - susp_time_ff;

   // position events see their own new coordinate
   assign pos_x = (s1_op_ff == OP_POS_X) ? s1_coord_ff : cur_x_ff;
   assign pos_y = (s1_op_ff == OP_POS_Y) ? s1_coord_ff : cur_y_ff;

   assign dx = (pos_x >= last_x_ff) ? (pos_x - last_x_ff) : (last_x_ff - pos_x);
   assign dy = (pos_y >= last_y_ff) ? (pos_y - last_y_ff) : (last_y_ff - pos_y);

   assign near = (DIST_BITS'(dx) < DIST_BITS'(feather_ff)) &&
                 (DIST_BITS'(dy) < DIST_BITS'(feather_ff));
   assign tap_in_window  = tap_gap  < TIME_BITS'(window);
   assign susp_in_window = susp_gap < TIME_BITS'(window);
   assign tc_less_one    = tap_count_ff - TAP_CNT_BITS'(1);

   always_comb begin
      counter_in   = counter_ff;
      last_time_in = last_time_ff;
      last_x_in    = last_x_ff;
      last_y_in    = last_y_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      armed_in     = armed_ff;
      susp_in      = susp_ff;
      susp_time_in = susp_time_ff;
      wake_in      = 1'b0;
      cnt_next     = MULT_BITS'(counter_ff);
      rec          = 1'b0;

      // screen on: the beat is passed through with no state change
      if (s1_soff_ff) begin
         unique case (s1_op_ff)
            OP_SLOT: begin
               counter_in   = '0;
               last_time_in = '0;
               last_x_in    = '0;
               last_y_in    = '0;
            end
            OP_RELEASE: begin
               armed_in = 1'b1;
            end
            OP_SUSPEND_EXIT: begin
               susp_in      = 1'b1;
               susp_time_in = s1_now_ff;
            end
            OP_POS_X, OP_POS_Y: begin
               cur_x_in = pos_x;
               cur_y_in = pos_y;
               susp_in  = 1'b0;
               // one detection step, only once per finger-down
               if (tap_count_ff != '0 && armed_ff) begin
                  armed_in = 1'b0;
                  priority if (counter_ff == tc_less_one) begin
                     // counter one below tap_count: record a tap, counted double after a recent resume
                     rec      = 1'b1;
                     cnt_next = MULT_BITS'(counter_ff) + MULT_BITS'(1)
                                + MULT_BITS'(susp_ff && susp_in_window);
                  end else if (counter_ff != '0 && counter_ff <= tap_count_ff) begin
                     if (near && tap_in_window) begin
                        cnt_next = MULT_BITS'(counter_ff) + MULT_BITS'(1);
                     end else begin
                        rec      = 1'b1;
                        cnt_next = MULT_BITS'(1);
                     end
                  end else begin
                     // counter zero or above tap_count: start over
                     rec      = 1'b1;
                     cnt_next = MULT_BITS'(1);
                  end

                  if (rec) begin
                     last_time_in = s1_now_ff;
                     last_x_in    = pos_x;
                     last_y_in    = pos_y;
                  end

                  if (cnt_next > MULT_BITS'(tap_count_ff)) begin
                     // sequence complete: fire and clear
                     wake_in      = 1'b1;
                     counter_in   = '0;
                     last_time_in = '0;
                     last_x_in    = '0;
                     last_y_in    = '0;
                  end else begin
                     counter_in = cnt_next[TAPS_BITS-1:0];
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TAP_COUNT_RST;
         feather_ff   <= FEATHER_RST;
         step_ff      <= STEP_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TAP_COUNT:   tap_count_ff <= csr_wdata[TAP_CNT_BITS-1:0];
            CSR_FEATHER:     feather_ff   <= csr_wdata[FEATHER_BITS-1:0];
            CSR_WINDOW_STEP: step_ff      <= csr_wdata[STEP_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_op_ff    <= op_type'(req_tuser);
         s1_coord_ff <= req_tdata[REQ_COORD_LSB +: COORD_BITS];
         s1_now_ff   <= req_tdata[REQ_NOW_LSB +: TIME_BITS];
         s1_soff_ff  <= req_tdata[REQ_SOFF_BIT];
      end
   end

   // tap state commits when the beat moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff   <= '0;
         last_time_ff <= '0;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         armed_ff     <= 1'b1;
         susp_ff      <= 1'b0;
         susp_time_ff <= '0;
      end else if (s1_fire) begin
         counter_ff   <= counter_in;
         last_time_ff <= last_time_in;
         last_x_ff    <= last_x_in;
         last_y_ff    <= last_y_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         armed_ff     <= armed_in;
         susp_ff      <= susp_in;
         susp_time_ff <= susp_time_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_wake_ff <= wake_in;
         rsp_taps_ff <= counter_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      rsp_tdata                                 = '0;
      rsp_tdata[RSP_WAKE_BIT]                   = rsp_wake_ff;
      rsp_tdata[RSP_TAPS_LSB +: TAPS_BITS]      = rsp_taps_ff;
   end

endmodule

FILE: hw/rtl/mtwd_checker.sv
// ----------------------------------------------------------------------------
// mtwd_checker
// port-level checks for the multi-tap wake detector
// ----------------------------------------------------------------------------
module mtwd_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [mtwd_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);
   import mtwd_pkg::*;

   // a stalled rsp beat holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // a wake clears the tap count in the same beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_WAKE_BIT] |-> rsp_tdata[RSP_TAPS_LSB +: TAPS_BITS] == '0)
      else $error("wake beat with nonzero tap count");

   // reset empties the result register
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // with no rsp beat pending the pipe always takes a new req beat
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req stalled while output empty");

endmodule

bind multi_tap_wake_detector mtwd_checker u_mtwd_checker (.*);

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the multi-tap wake detector: a short table of
// directed touch events, then random tap gestures and noise under a range of
// register settings, with random stalls on both streams; every response beat
// is checked against a typed row's values or the in-bench tap-sequence predictor
// ----------------------------------------------------------------------------
module tb_top;
   import mtwd_pkg::*;

   // ignored operation codes that the package leaves unnamed
   localparam logic [OP_BITS-1:0] OP_IGNORED_LO = 3'd5;
   localparam logic [OP_BITS-1:0] OP_IGNORED_HI = 3'd7;
   localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
   localparam int PHASE_EVENTS = 170;
   localparam int NUM_PHASES   = 10;
   localparam int DRAIN_CYCLES = 4;

   // one response beat as the bench sees it
   typedef struct packed {
      bit                 wake;
      bit [TAPS_BITS-1:0] taps;
   } wake_result_type;

   // one directed event; typed rows carry their response, the rest use the predictor
   typedef struct packed {
      logic [OP_BITS-1:0]    op;
      bit [COORD_BITS-1:0]   coord;
      bit [TIME_BITS-1:0]    stamp;
      bit                    soff;
      bit                    typed;
      bit                    wake;
      bit [TAPS_BITS-1:0]    taps;
   } touch_row_type;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic [OP_BITS-1:0]       req_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_we;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   multi_tap_wake_detector DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 4 ns period
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // tap-sequence predictor: shadow registers and shadow tap state
   // ------------------------------------------------------------------------
   bit [TAP_CNT_BITS-1:0] cfg_taps;
   bit [FEATHER_BITS-1:0] cfg_feather;
   bit [STEP_BITS-1:0]    cfg_step;

   bit [TAPS_BITS-1:0]    tap_cnt;
   bit [TIME_BITS-1:0]    prev_tap_ms;
   bit [COORD_BITS-1:0]   prev_tap_x;
   bit [COORD_BITS-1:0]   prev_tap_y;
   bit [COORD_BITS-1:0]   cur_x;
   bit [COORD_BITS-1:0]   cur_y;
   bit                    armed;
   bit                    exit_pending;
   bit [TIME_BITS-1:0]    exit_ms;

   // expected response beats, oldest first
   wake_result_type pending_results[$];

   int  fail_count;
   bit  no_idle;          // phase runs at full rate on both streams
   bit [TIME_BITS-1:0] touch_ms;  // running time base for random gestures
   int  live_events;      // events in this phase that the block acts on

   // tap window in ms for the current settings
   function automatic int tap_window();
      return int'(cfg_step) * (int'(cfg_taps) + 1);
   endfunction

   function automatic void clear_taps();
      tap_cnt     = '0;
      prev_tap_ms = '0;
      prev_tap_x  = '0;
      prev_tap_y  = '0;
   endfunction

   function automatic void start_tap(bit [TIME_BITS-1:0] now_ms);
      prev_tap_ms = now_ms;
      prev_tap_x  = cur_x;
      prev_tap_y  = cur_y;
      tap_cnt     = tap_cnt + 1'b1;
   endfunction

   function automatic bit [COORD_BITS-1:0] coord_gap(bit [COORD_BITS-1:0] a,
                                                     bit [COORD_BITS-1:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   // one detection pass on a position event; returns the wake flag
   function automatic bit run_tap(bit [TIME_BITS-1:0] now_ms);
      bit [TIME_BITS-1:0] window;
      bit [TIME_BITS-1:0] since_exit;
      bit [TIME_BITS-1:0] since_tap;
      bit                 fire;
      fire       = 1'b0;
      window     = TIME_BITS'(tap_window());
      since_exit = now_ms - exit_ms;
      since_tap  = now_ms - prev_tap_ms;
      if (cfg_taps != 0 && armed) begin
         armed = 1'b0;
         if (tap_cnt == cfg_taps - 1'b1) begin
            // one tap short of the goal; a recent resume counts the tap twice
            start_tap(now_ms);
            if (exit_pending && since_exit < window)
               tap_cnt = tap_cnt + 1'b1;
         end else if (tap_cnt >= 1 && tap_cnt <= cfg_taps) begin
            if (coord_gap(cur_x, prev_tap_x) < cfg_feather &&
                coord_gap(cur_y, prev_tap_y) < cfg_feather &&
                since_tap < window) begin
               tap_cnt = tap_cnt + 1'b1;
            end else begin
               clear_taps();
               start_tap(now_ms);
            end
         end else begin
            // counter zero or above the current goal: fresh sequence
            clear_taps();
            start_tap(now_ms);
         end
         if (tap_cnt > cfg_taps) begin
            fire = 1'b1;
            clear_taps();
         end
      end
      exit_pending = 1'b0;
      return fire;
   endfunction

   function automatic wake_result_type predict_event(logic [OP_BITS-1:0] op,
                                                     bit [COORD_BITS-1:0] coord,
                                                     bit [TIME_BITS-1:0] now_ms,
                                                     bit soff);
      wake_result_type res;
      res.wake = 1'b0;
      if (soff) begin
         case (op)
            OP_SLOT:         clear_taps();
            OP_RELEASE:      armed = 1'b1;
            OP_POS_X: begin
               cur_x    = coord;
               res.wake = run_tap(now_ms);
            end
            OP_POS_Y: begin
               cur_y    = coord;
               res.wake = run_tap(now_ms);
            end
            OP_SUSPEND_EXIT: begin
               exit_pending = 1'b1;
               exit_ms      = now_ms;
            end
            default: ;
         endcase
      end
      res.taps = tap_cnt;
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // random timing helpers
   // ------------------------------------------------------------------------

   // stall length: mostly short, now and then long
   function automatic int stall_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80)      return $urandom_range(1, 3);
      else if (r < 96) return $urandom_range(4, 8);
      else             return $urandom_range(10, 30);
   endfunction

   // spacing between taps, aimed around the window edge
   function automatic bit [TIME_BITS-1:0] pick_dt();
      int window;
      int r;
      window = tap_window();
      r      = $urandom_range(0, 99);
      if (window == 0)  return $urandom_range(0, 20);
      else if (r < 75)  return $urandom_range(0, window - 1);
      else if (r < 85)  return window - 1;
      else if (r < 92)  return window;
      else              return $urandom_range(window, window * 3 + 10);
   endfunction

   // a coordinate near base, often right at the feather edge
   function automatic bit [COORD_BITS-1:0] near_coord(bit [COORD_BITS-1:0] base);
      int fd;
      int mag;
      int r;
      int v;
      fd = int'(cfg_feather);
      r  = $urandom_range(0, 99);
      if (fd == 0)      mag = $urandom_range(0, 3);
      else if (r < 60)  mag = $urandom_range(0, fd - 1);
      else if (r < 80)  mag = fd - 1;
      else              mag = fd;
      v = ($urandom_range(0, 1) != 0) ? int'(base) + mag : int'(base) - mag;
      if (v < 0)         v = 0;
      if (v > COORD_MAX) v = COORD_MAX;
      return COORD_BITS'(v);
   endfunction

   // ------------------------------------------------------------------------
   // stimulus side
   // ------------------------------------------------------------------------

   // drive one request beat, wait for the handshake, record the expected
   // response, then sometimes idle for a random gap
   task automatic send_event(logic [OP_BITS-1:0] op, bit [COORD_BITS-1:0] coord,
                             bit [TIME_BITS-1:0] now_ms, bit soff,
                             bit typed = 1'b0, bit twake = 1'b0,
                             bit [TAPS_BITS-1:0] ttaps = '0);
      logic [REQ_DATA_BITS-1:0] beat;
      wake_result_type          want;
      int                       gap;
      beat = '0;
      beat[REQ_COORD_LSB +: COORD_BITS] = coord;
      beat[REQ_NOW_LSB +: TIME_BITS]    = now_ms;
      beat[REQ_SOFF_BIT]                = soff;
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      // beat taken at this edge
      want = predict_event(op, coord, now_ms, soff);
      if (typed) begin
         want.wake = twake;
         want.taps = ttaps;
      end
      pending_results.push_back(want);
      gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : stall_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // random-phase event at the running time base; counts events that matter
   task automatic emit_event(logic [OP_BITS-1:0] op, bit [COORD_BITS-1:0] coord,
                             bit soff);
      if (soff && op <= OP_SUSPEND_EXIT)
         live_events++;
      send_event(op, coord, touch_ms, soff);
   endtask

   // stop sending and let every outstanding beat come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // program all three registers back to back while the block is idle
   task automatic apply_config(bit [TAP_CNT_BITS-1:0] taps, bit [FEATHER_BITS-1:0] feather,
                               bit [STEP_BITS-1:0] step);
      csr_we    <= 1'b1;
      csr_index <= CSR_TAP_COUNT;
      csr_wdata <= CSR_DATA_BITS'(taps);
      @(posedge clock);
      cfg_taps   = taps;
      csr_index <= CSR_FEATHER;
      csr_wdata <= CSR_DATA_BITS'(feather);
      @(posedge clock);
      cfg_feather = feather;
      csr_index  <= CSR_WINDOW_STEP;
      csr_wdata  <= CSR_DATA_BITS'(step);
      @(posedge clock);
      cfg_step = step;
      csr_we  <= 1'b0;
   endtask

   // random phase: mostly well-formed tap gestures, the rest noise
   task automatic run_phase(int target);
      int                   ntaps;
      int                   t;
      int                   r;
      bit [COORD_BITS-1:0]  base_x;
      bit [COORD_BITS-1:0]  base_y;
      bit                   soff;
      live_events = 0;
      while (live_events < target) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            // gesture: optional resume, then a run of taps around one spot
            ntaps  = $urandom_range(1, int'(cfg_taps) + 2);
            base_x = COORD_BITS'($urandom_range(0, COORD_MAX));
            base_y = COORD_BITS'($urandom_range(0, COORD_MAX));
            if ($urandom_range(0, 3) == 0)
               emit_event(OP_SUSPEND_EXIT, COORD_BITS'($urandom_range(0, COORD_MAX)), 1'b1);
            for (t = 0; t < ntaps; t++) begin
               touch_ms += pick_dt();
               soff = ($urandom_range(0, 29) != 0);
               // a missing release leaves the block disarmed
               if ($urandom_range(0, 9) != 0)
                  emit_event(OP_RELEASE, COORD_BITS'($urandom_range(0, COORD_MAX)), soff);
               if ($urandom_range(0, 1) != 0) begin
                  emit_event(OP_POS_X, near_coord(base_x), soff);
                  emit_event(OP_POS_Y, near_coord(base_y), soff);
               end else begin
                  emit_event(OP_POS_Y, near_coord(base_y), soff);
                  emit_event(OP_POS_X, near_coord(base_x), soff);
               end
            end
         end else begin
            // noise: any code, any coordinate, jumps in time including wrap
            r = $urandom_range(0, 9);
            if (r < 5)       touch_ms += pick_dt();
            else if (r < 8)  touch_ms = $urandom;
            else             touch_ms = '1 - TIME_BITS'($urandom_range(0, 2000));
            emit_event(OP_BITS'($urandom_range(0, 7)),
                       COORD_BITS'($urandom_range(0, COORD_MAX)),
                       $urandom_range(0, 99) < 85);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // response side: random ready with stretches of full rate
   // ------------------------------------------------------------------------
   int ready_left;

   always @(posedge clock) begin
      if (no_idle) begin
         rsp_tready <= 1'b1;
         ready_left <= 0;
      end else if (ready_left != 0) begin
         ready_left <= ready_left - 1;
      end else if ($urandom_range(0, 3) != 0) begin
         rsp_tready <= 1'b1;
         ready_left <= $urandom_range(0, 15);
      end else begin
         rsp_tready <= 1'b0;
         ready_left <= stall_len() - 1;
      end
   end

   // first ten failures are printed, the rest only counted
   function automatic void note_failure(string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch at %0t: %s", $realtime, msg);
   endfunction

   wake_result_type seen_beat;
   wake_result_type oldest_beat;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_beat.wake = rsp_tdata[RSP_WAKE_BIT];
         seen_beat.taps = rsp_tdata[RSP_TAPS_LSB +: TAPS_BITS];
         if (pending_results.size() == 0) begin
            note_failure($sformatf("beat with nothing pending: wake %0b taps %0d",
                                   seen_beat.wake, seen_beat.taps));
         end else begin
            oldest_beat = pending_results.pop_front();
            if (seen_beat.wake != oldest_beat.wake)
               note_failure($sformatf("wake: expected %0b, got %0b",
                                      oldest_beat.wake, seen_beat.wake));
            if (seen_beat.taps != oldest_beat.taps)
               note_failure($sformatf("taps_seen: expected %0d, got %0d",
                                      oldest_beat.taps, seen_beat.taps));
         end
      end
   end

   // ------------------------------------------------------------------------
   // directed table, run at the reset settings (one extra tap, feather 200,
   // step 100, so a 200 ms window)
   // ------------------------------------------------------------------------
   localparam int NUM_ROWS = 25;
   touch_row_type touch_rows [NUM_ROWS] = '{
      // screen on: nothing moves
      '{OP_POS_Y,        12'd0,    32'd0,          1'b0, 1'b1, 1'b0, 4'd0},
      // ignored codes, extreme fields
      '{OP_IGNORED_LO,   12'd4095, 32'hFFFF_FFFF,  1'b1, 1'b1, 1'b0, 4'd0},
      '{OP_IGNORED_HI,   12'd0,    32'd0,          1'b1, 1'b1, 1'b0, 4'd0},
      // first tap, then a close second one: wake
      '{OP_POS_X,        12'd100,  32'd1000,       1'b1, 1'b0, 1'b0, 4'd0},
      '{OP_RELEASE,      12'd0,    32'd1010,       1'b1, 1'b0, 1'b0, 4'd0},
      '{OP_POS_X,        12'd150,  32'd1050,       1'b1, 1'b0, 1'b0, 4'd0},
      // tap at the far corner on y, then a far x: sequence restarts
      '{OP_RELEASE,      12'd0,    32'd1060,       1'b1, 1'b0, 1'b0, 4'd0},
      '{OP_POS_Y,        12'd4095, 32'd1100,       1'b1, 1'b0, 1'b0, 4'd0},
      '{OP_RELEASE,      12'd0,    32'd1120,       1'b1, 1'b0, 1'b0, 4'd0},
      '{OP_POS_X,        12'd4095, 32'd1150,       1'b1, 1'b0, 1'b0, 4'd0},
      // slot change clears the count
      '{OP_SLOT,         12'd0,    32'd1200,       1'b1, 1'b1, 1'b0, 4'd0},
      // resume bonus: one tap right after a resume is enough
      '{OP_SUSPEND_EXIT, 12'd0,    32'd2000,       1'b1, 1'b0, 1'b0, 4'd0},
      '{OP_RELEASE,      12'd0,    32'd2050,       1'b1, 1'b0, 1'b0, 4'd0},
      '{OP_POS_X,        12'd10,   32'd2100,       1'b1, 1'b0, 1'b0, 4'd0},
      // two taps straddling the time wrap
      '{OP_RELEASE,      12'd0,    32'hFFFF_FFF0,  1'b1, 1'b0, 1'b0, 4'd0},
      '{OP_POS_X,        12'd20,   32'hFFFF_FFF0,  1'b1, 1'b0, 1'b0, 4'd0},
      '{OP_RELEASE,      12'd0,    32'h0000_0010,  1'b1, 1'b0, 1'b0, 4'd0},
      '{OP_POS_X,        12'd30,   32'h0000_0010,  1'b1, 1'b0, 1'b0, 4'd0},
      // no release before this one: only the coordinate is stored
      '{OP_POS_X,        12'd40,   32'h0000_0020,  1'b1, 1'b0, 1'b0, 4'd0},
      // second tap exactly one window later does not chain
      '{OP_RELEASE,      12'd0,    32'h0001_0000,  1'b1, 1'b0, 1'b0, 4'd0},
      '{OP_POS_X,        12'd40,   32'h0001_0000,  1'b1, 1'b0, 1'b0, 4'd0},
      '{OP_RELEASE,      12'd0,    32'h0001_00C8,  1'b1, 1'b0, 1'b0, 4'd0},
      '{OP_POS_X,        12'd40,   32'h0001_00C8,  1'b1, 1'b0, 1'b0, 4'd0},
      // slot change with the screen on is ignored, then taken
      '{OP_SLOT,         12'd0,    32'h0001_0100,  1'b0, 1'b1, 1'b0, 4'd1},
      '{OP_SLOT,         12'd0,    32'h0001_0100,  1'b1, 1'b1, 1'b0, 4'd0}
   };

   // register settings per random phase, extremes included; a high tap goal
   // followed by lower ones leaves the counter out of step now and then
   bit [TAP_CNT_BITS-1:0] phase_taps    [NUM_PHASES] = '{2, 9, 0, 3, 2, 5, 1, 9, 3, 1};
   bit [FEATHER_BITS-1:0] phase_feather [NUM_PHASES] =
      '{300, 4095, 100, 0, 250, 1, 4095, 50, 600, 200};
   bit [STEP_BITS-1:0]    phase_step    [NUM_PHASES] =
      '{150, 1000, 100, 200, 0, 1, 1000, 40, 300, 100};

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      no_idle    = 1'b0;
      ready_left = 0;
      fail_count = 0;
      reset      = 1'b1;

      // predictor state after reset
      cfg_taps     = TAP_COUNT_RST;
      cfg_feather  = FEATHER_RST;
      cfg_step     = STEP_RST;
      clear_taps();
      cur_x        = '0;
      cur_y        = '0;
      armed        = 1'b1;
      exit_pending = 1'b0;
      exit_ms      = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed table at the reset settings
      foreach (touch_rows[i])
         send_event(touch_rows[i].op, touch_rows[i].coord, touch_rows[i].stamp,
                    touch_rows[i].soff, touch_rows[i].typed, touch_rows[i].wake,
                    touch_rows[i].taps);
      drain();

      // random phases, every third one at full rate on both sides
      touch_ms = $urandom;
      for (int p = 0; p < NUM_PHASES; p++) begin
         apply_config(phase_taps[p], phase_feather[p], phase_step[p]);
         no_idle = (p % 3 == 1);
         run_phase(PHASE_EVENTS);
         drain();
      end

      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
